/* hw/rtl/ple_pkg.sv */
package ple_pkg;

    // List geometry
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths of the channels
    localparam int POS_W  = 8;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 7;

    // Width that holds both a request position and the entry count, plus one
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Request kinds
    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_GET    = 2'd2,
        FUNC_LOCATE = 2'd3
    } func_t;

endpackage

/* hw/rtl/ple_req_if.sv */
interface ple_req_if;
    import ple_pkg::*;

    logic                     valid;
    logic                     ready;
    func_t                    func;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value_in;

    modport source (output valid, output func, output position, output value_in,
                    input ready);
    modport sink   (input valid, input func, input position, input value_in,
                    output ready);
endinterface

/* hw/rtl/ple_rsp_if.sv */
interface ple_rsp_if;
    import ple_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic signed [DATA_W-1:0] value_out;
    logic [LEN_W-1:0]         found_position;
    logic [LEN_W-1:0]         length;

    modport source (output valid, output ok, output value_out, output found_position,
                    output length, input ready);
    modport sink   (input valid, input ok, input value_out, input found_position,
                    input length, output ready);
endinterface

/* hw/rtl/positional_list_engine.sv */
// Channel | Dir | Payload                                  | Beat taken when
// req     | in  | func, position, value_in                 | valid && ready
// rsp     | out | ok, value_out, found_position, length    | valid && ready
//
// One request is handled at a time. The list lives in one RAM with a
// registered read; a single read/write port pair moves one entry per cycle.
// Insert and delete move each entry from the position to the tail, get reads
// one entry, and locate reads in order until a hit or the end of the list.
// Reset clears the count and control registers; no RAM clearing pass is needed.
// A finished result waits in the output register while the next beat is taken.
module positional_list_engine (
    input  logic      clk,
    input  logic      rst_n,
    ple_req_if.sink   req,
    ple_rsp_if.source rsp
);
    import ple_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH, S_EMIT} state_t;

    // List storage
    logic signed [DATA_W-1:0] mem [CAPACITY];
    logic signed [DATA_W-1:0] rd_data_reg;

    // Control and working registers
    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    func_t                    op_reg, op_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0]         ins_addr_reg, ins_addr_next;
    logic [CNT_W-1:0]         issue_left_reg, issue_left_next;
    logic [IDX_W-1:0]         issue_addr_reg, issue_addr_next;
    logic                     dir_up_reg, dir_up_next;
    logic                     rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]         rd_addr_reg, rd_addr_next;
    logic                     found_reg, found_next;
    logic                     res_ok_reg, res_ok_next;
    logic signed [DATA_W-1:0] res_value_reg, res_value_next;
    logic [CNT_W-1:0]         res_fpos_reg, res_fpos_next;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic                     out_ok_reg, out_ok_next;
    logic signed [DATA_W-1:0] out_value_reg, out_value_next;
    logic [LEN_W-1:0]         out_fpos_reg, out_fpos_next;
    logic [LEN_W-1:0]         out_len_reg, out_len_next;

    // RAM port controls
    logic                     rd_en;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic signed [DATA_W-1:0] wr_data;

    logic [CMP_W-1:0]         pos_x;
    logic [CMP_W-1:0]         n_x;
    logic                     ins_ok;
    logic                     acc_ok;
    logic                     match;

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.ok             = out_ok_reg;
    assign rsp.value_out      = out_value_reg;
    assign rsp.found_position = out_fpos_reg;
    assign rsp.length         = out_len_reg;

    // Range checks on the incoming position
    assign pos_x  = CMP_W'(req.position);
    assign n_x    = CMP_W'(count_reg);
    assign ins_ok = (n_x < CMP_W'(CAPACITY)) && (pos_x != '0) && (pos_x <= n_x + CMP_W'(1));
    assign acc_ok = (pos_x != '0) && (pos_x <= n_x);

    // Locate hit on the entry returning from the RAM
    assign match = rd_valid_reg && (op_reg == FUNC_LOCATE) && !found_reg
                   && (rd_data_reg == val_reg);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        ins_addr_next   = ins_addr_reg;
        issue_left_next = issue_left_reg;
        issue_addr_next = issue_addr_reg;
        dir_up_next     = dir_up_reg;
        rd_valid_next   = 1'b0;
        rd_addr_next    = rd_addr_reg;
        found_next      = found_reg;
        res_ok_next     = res_ok_reg;
        res_value_next  = res_value_reg;
        res_fpos_next   = res_fpos_reg;
        out_valid_next  = out_valid_reg;
        out_ok_next     = out_ok_reg;
        out_value_next  = out_value_reg;
        out_fpos_next   = out_fpos_reg;
        out_len_next    = out_len_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;

        // Result taken downstream
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next         = req.func;
                    val_next        = req.value_in;
                    found_next      = 1'b0;
                    res_ok_next     = 1'b0;
                    res_value_next  = '0;
                    res_fpos_next   = '0;
                    ins_addr_next   = IDX_W'(pos_x - CMP_W'(1));
                    issue_left_next = '0;
                    issue_addr_next = '0;
                    dir_up_next     = 1'b1;
                    state_next      = S_EMIT;
                    case (req.func)
                        FUNC_INSERT:
                        begin
                            if (ins_ok)
                            begin
                                // walk from the tail down to the insert point
                                issue_left_next = CNT_W'(n_x + CMP_W'(1) - pos_x);
                                issue_addr_next = IDX_W'(n_x - CMP_W'(1));
                                dir_up_next     = 1'b0;
                                res_ok_next     = 1'b1;
                                state_next      = S_SCAN;
                            end
                        end
                        FUNC_DELETE:
                        begin
                            if (acc_ok)
                            begin
                                // read the victim, then pull the rest forward
                                issue_left_next = CNT_W'(n_x + CMP_W'(1) - pos_x);
                                issue_addr_next = IDX_W'(pos_x - CMP_W'(1));
                                res_ok_next     = 1'b1;
                                state_next      = S_SCAN;
                            end
                        end
                        FUNC_GET:
                        begin
                            if (acc_ok)
                            begin
                                issue_left_next = CNT_W'(1);
                                issue_addr_next = IDX_W'(pos_x - CMP_W'(1));
                                res_ok_next     = 1'b1;
                                state_next      = S_SCAN;
                            end
                        end
                        FUNC_LOCATE:
                        begin
                            issue_left_next = count_reg;
                            state_next      = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Consume the entry read last cycle
                if (rd_valid_reg)
                begin
                    case (op_reg)
                        FUNC_INSERT:
                        begin
                            wr_en   = 1'b1;
                            wr_addr = rd_addr_reg + IDX_W'(1);
                            wr_data = rd_data_reg;
                        end
                        FUNC_DELETE:
                        begin
                            if (rd_addr_reg == ins_addr_reg)
                            begin
                                res_value_next = rd_data_reg;
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_addr = rd_addr_reg - IDX_W'(1);
                                wr_data = rd_data_reg;
                            end
                        end
                        FUNC_GET:
                        begin
                            res_value_next = rd_data_reg;
                        end
                        FUNC_LOCATE:
                        begin
                            if (match)
                            begin
                                found_next    = 1'b1;
                                res_ok_next   = 1'b1;
                                res_fpos_next = CNT_W'(rd_addr_reg) + CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            wr_en = 1'b0;
                        end
                    endcase
                end

                // Issue the next read; a write beside it trails it by two entries
                if ((issue_left_reg != '0) && !found_reg && !match)
                begin
                    rd_en           = 1'b1;
                    rd_valid_next   = 1'b1;
                    rd_addr_next    = issue_addr_reg;
                    issue_left_next = issue_left_reg - CNT_W'(1);
                    issue_addr_next = dir_up_reg ? issue_addr_reg + IDX_W'(1)
                                                 : issue_addr_reg - IDX_W'(1);
                end

                if (((issue_left_reg == '0) && !rd_valid_reg) || found_reg)
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                case (op_reg)
                    FUNC_INSERT:
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = ins_addr_reg;
                        wr_data    = val_reg;
                        count_next = count_reg + CNT_W'(1);
                    end
                    FUNC_DELETE:
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    default:
                    begin
                        count_next = count_reg;
                    end
                endcase
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_value_next = res_value_reg;
                    out_fpos_next  = LEN_W'(res_fpos_reg);
                    out_len_next   = LEN_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            op_reg         <= FUNC_INSERT;
            val_reg        <= '0;
            ins_addr_reg   <= '0;
            issue_left_reg <= '0;
            issue_addr_reg <= '0;
            dir_up_reg     <= 1'b1;
            rd_valid_reg   <= 1'b0;
            rd_addr_reg    <= '0;
            found_reg      <= 1'b0;
            res_ok_reg     <= 1'b0;
            res_value_reg  <= '0;
            res_fpos_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_ok_reg     <= 1'b0;
            out_value_reg  <= '0;
            out_fpos_reg   <= '0;
            out_len_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            op_reg         <= op_next;
            val_reg        <= val_next;
            ins_addr_reg   <= ins_addr_next;
            issue_left_reg <= issue_left_next;
            issue_addr_reg <= issue_addr_next;
            dir_up_reg     <= dir_up_next;
            rd_valid_reg   <= rd_valid_next;
            rd_addr_reg    <= rd_addr_next;
            found_reg      <= found_next;
            res_ok_reg     <= res_ok_next;
            res_value_reg  <= res_value_next;
            res_fpos_reg   <= res_fpos_next;
            out_valid_reg  <= out_valid_next;
            out_ok_reg     <= out_ok_next;
            out_value_reg  <= out_value_next;
            out_fpos_reg   <= out_fpos_next;
            out_len_reg    <= out_len_next;
        end
    end

    // Entry RAM: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[issue_addr_reg];
        end
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (wr_addr != issue_addr_reg))
        else $error("RAM read and write hit the same entry");

    a_fail_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ok) |-> ((rsp.value_out == '0) && (rsp.found_position == '0)))
        else $error("failed result carries data");

    a_shift_stays_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && rd_valid_reg) |-> !req.ready)
        else $error("request taken during a list walk");

endmodule
